// ----- sv/pkvm_pkg.sv -----
// Shared types, widths and codes for the paged KV slot mapper.
`default_nettype none

package pkvm_pkg;

  // Parameter defaults
  localparam int DEF_MAX_SEQS            = 256;
  localparam int DEF_MAX_BLOCKS_PER_SEQ  = 256;
  localparam int DEF_MAX_TOKENS_PER_ITEM = 64;
  localparam int DEF_PHYS_BLOCK_BITS     = 20;

  // Field widths
  localparam int BS_W       = 11;
  localparam int MBT_W      = 16;
  localparam int SEQ_IDX_W  = 8;
  localparam int BLK_IDX_W  = 8;
  localparam int PHYS_W     = 20;
  localparam int NTOK_W     = 7;
  localparam int CACHED_W   = 18;
  localparam int POS_W      = 19;
  localparam int SLOT_W     = 30;
  localparam int TIX_W      = 16;
  localparam int QS_W       = 16;
  localparam int MAXB_W     = 10;
  localparam int STATUS_W   = 2;
  localparam int ACC_W      = 17;
  localparam int DIV_W      = 19;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Register reset values and limits
  localparam logic [BS_W-1:0]   BS_RESET  = 11'd16;
  localparam logic [BS_W-1:0]   BS_MAX    = 11'd1024;
  localparam logic [MBT_W-1:0]  MBT_RESET = 16'd8192;
  localparam logic [ACC_W-1:0]  ACC_MAX   = 17'h1FFFF;
  localparam logic [MAXB_W-1:0] MAXB_MAX  = 10'd1023;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BATCHED = 1'b1;

  // Request types
  localparam logic REQ_TABLE = 1'b0;
  localparam logic REQ_SEQ   = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LIMIT   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_NEED,
    S_POS,
    S_RD,
    S_MUL,
    S_PUT,
    S_FLAG
  } state_t;

endpackage

`default_nettype wire

// ----- sv/pkvm_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none

module pkvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                           wdata,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- sv/pkvm_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module pkvm_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [pkvm_pkg::DIV_W-1:0] dividend,
  input  wire logic [pkvm_pkg::BS_W-1:0]  divisor,
  output logic                            done,
  output logic      [pkvm_pkg::DIV_W-1:0] quot,
  output logic      [pkvm_pkg::BS_W-1:0]  rem
);

  localparam int CNT_W = $clog2(pkvm_pkg::DIV_W + 1);

  logic [CNT_W-1:0]            cnt;
  logic [pkvm_pkg::BS_W:0]     trial;
  logic [pkvm_pkg::BS_W:0]     diff;
  logic                        ge;

  assign trial = {rem, quot[pkvm_pkg::DIV_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(pkvm_pkg::DIV_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
    end else if (cnt != '0) begin
      rem  <= ge ? diff[pkvm_pkg::BS_W-1:0] : trial[pkvm_pkg::BS_W-1:0];
      quot <= {quot[pkvm_pkg::DIV_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ----- sv/paged_kv_slot_mapper.sv -----
// Top level of the paged KV slot mapper: table store, divider sequencer, result register.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | req_type, start_batch, seq_index, block_index,
//          |                      | phys_block, new_tokens, cached_len
//  out     | out_valid/out_ready  | token_valid, position, slot, token_index,
//          |                      | query_start, max_blocks, status, last
//
// Table-write request: written in the cycle it is accepted, no result.
// Sequence request: a lookup step, the blocks-needed divide and the position divide,
// then one token per cycle while out_ready allows, plus a table read and a multiply at the
// start and at each block boundary. Flagged or empty requests give one flag result instead.
// The shared 19-step divider and the single block-table port set the pace of a request.
// in_ready is high only while idle; out_ready low holds the sequencer on the pending token.
// Reset drops table lengths, clears batch accumulators, restores config; block table stays.
`default_nettype none

module paged_kv_slot_mapper #(
  parameter int MAX_SEQS            = pkvm_pkg::DEF_MAX_SEQS,
  parameter int MAX_BLOCKS_PER_SEQ  = pkvm_pkg::DEF_MAX_BLOCKS_PER_SEQ,
  parameter int MAX_TOKENS_PER_ITEM = pkvm_pkg::DEF_MAX_TOKENS_PER_ITEM,
  parameter int PHYS_BLOCK_BITS     = pkvm_pkg::DEF_PHYS_BLOCK_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pkvm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pkvm_pkg::CFG_DATA_W-1:0] cfg_data,
  // requests
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            req_type,
  input  wire logic                            start_batch,
  input  wire logic [pkvm_pkg::SEQ_IDX_W-1:0]  seq_index,
  input  wire logic [pkvm_pkg::BLK_IDX_W-1:0]  block_index,
  input  wire logic [pkvm_pkg::PHYS_W-1:0]     phys_block,
  input  wire logic [pkvm_pkg::NTOK_W-1:0]     new_tokens,
  input  wire logic [pkvm_pkg::CACHED_W-1:0]   cached_len,
  // results
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 token_valid,
  output logic      [pkvm_pkg::POS_W-1:0]      position,
  output logic      [pkvm_pkg::SLOT_W-1:0]     slot,
  output logic      [pkvm_pkg::TIX_W-1:0]      token_index,
  output logic      [pkvm_pkg::QS_W-1:0]       query_start,
  output logic      [pkvm_pkg::MAXB_W-1:0]     max_blocks,
  output logic      [pkvm_pkg::STATUS_W-1:0]   status,
  output logic                                 last
);

  localparam int SEQ_W     = (MAX_SEQS > 1) ? $clog2(MAX_SEQS) : 1;
  localparam int BLK_W     = (MAX_BLOCKS_PER_SEQ > 1) ? $clog2(MAX_BLOCKS_PER_SEQ) : 1;
  localparam int SEQ_DEPTH = 1 << SEQ_W;
  localparam int TBL_DEPTH = 1 << (SEQ_W + BLK_W);
  localparam int LCNT_W    = $clog2(MAX_BLOCKS_PER_SEQ + 1);
  localparam int PROD_W    = PHYS_BLOCK_BITS + pkvm_pkg::BS_W;
  localparam int ACC_W     = pkvm_pkg::ACC_W;
  localparam int DIV_W     = pkvm_pkg::DIV_W;
  localparam int BS_W      = pkvm_pkg::BS_W;
  localparam int NTOK_W    = pkvm_pkg::NTOK_W;

  // config registers
  logic [BS_W-1:0]               block_size;
  logic [pkvm_pkg::MBT_W-1:0]    max_batched_tokens;

  pkvm_pkg::state_t              state;
  pkvm_pkg::state_t              state_next;

  // per-request registers
  logic                          start_q;
  logic [SEQ_W-1:0]              seq_q;
  logic                          seq_ok_q;
  logic [NTOK_W-1:0]             n_q;
  logic [pkvm_pkg::CACHED_W-1:0] cached_q;
  logic [BS_W-1:0]               bs_q;
  logic [LCNT_W-1:0]             tlen_q;
  logic [ACC_W-1:0]              qs_q;
  logic [DIV_W-1:0]              blk;
  logic [BS_W-1:0]               off;
  logic [NTOK_W-1:0]             j;
  logic [PROD_W-1:0]             prod;
  logic [pkvm_pkg::STATUS_W-1:0] stat_flag;

  // batch accumulators
  logic [ACC_W-1:0]              qs_acc;
  logic [ACC_W-1:0]              tot_acc;
  logic [pkvm_pkg::MAXB_W-1:0]   max_seen;
  logic [SEQ_DEPTH-1:0]          lvalid;

  // request decode
  logic                          in_fire;
  logic [31:0]                   seq_in32;
  logic [31:0]                   bidx32;
  logic                          seq_in_ok;
  logic                          bidx_ok;
  logic                          tbl_we;
  logic [SEQ_W-1:0]              seq_in_idx;
  logic [BLK_W-1:0]              bidx_idx;
  logic [NTOK_W-1:0]             n_clamp;
  logic [BS_W-1:0]               bs_eff;

  // memories
  logic [LCNT_W-1:0]             lcnt_rd;
  logic [PHYS_BLOCK_BITS-1:0]    pb_rd;
  logic [SEQ_W+BLK_W-1:0]        tbl_addr;

  // divider
  logic                          div_start;
  logic [DIV_W-1:0]              div_dividend;
  logic                          div_done;
  logic [DIV_W-1:0]              div_quot;
  logic [BS_W-1:0]               div_rem;
  logic [DIV_W-1:0]              need_num;

  // batch update, valid when the blocks-needed divide completes
  logic [ACC_W-1:0]              base_qs;
  logic [ACC_W-1:0]              base_tot;
  logic [pkvm_pkg::MAXB_W-1:0]   base_max;
  logic [ACC_W:0]                qs_sum;
  logic [ACC_W:0]                tot_sum;
  logic [ACC_W-1:0]              qs_new;
  logic [ACC_W-1:0]              tot_new;
  logic [pkvm_pkg::MAXB_W-1:0]   max_new;
  logic [pkvm_pkg::STATUS_W-1:0] stat_new;

  // output control
  logic                          out_free;
  logic                          out_load_tok;
  logic                          out_load_flag;
  logic                          tok_last;
  logic                          blk_wrap;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == pkvm_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;

  assign seq_in32   = 32'(seq_index);
  assign bidx32     = 32'(block_index);
  assign seq_in_ok  = seq_in32 < 32'(MAX_SEQS);
  assign bidx_ok    = bidx32 < 32'(MAX_BLOCKS_PER_SEQ);
  assign seq_in_idx = seq_in32[SEQ_W-1:0];
  assign bidx_idx   = bidx32[BLK_W-1:0];
  assign tbl_we     = in_fire && (req_type == pkvm_pkg::REQ_TABLE) && seq_in_ok && bidx_ok;

  assign n_clamp = (32'(new_tokens) > 32'(MAX_TOKENS_PER_ITEM)) ?
                   NTOK_W'(MAX_TOKENS_PER_ITEM) : new_tokens;
  assign bs_eff  = (block_size == '0) ? BS_W'(1) :
                   ((block_size > pkvm_pkg::BS_MAX) ? pkvm_pkg::BS_MAX : block_size);

  // table length per sequence; lvalid marks entries written since reset
  pkvm_ram #(
    .WIDTH(LCNT_W),
    .DEPTH(SEQ_DEPTH)
  ) u_lcnt (
    .clk  (clk),
    .we   (tbl_we),
    .addr (seq_in_idx),
    .wdata(LCNT_W'(bidx32 + 32'd1)),
    .rdata(lcnt_rd)
  );

  assign tbl_addr = (state == pkvm_pkg::S_IDLE) ? {seq_in_idx, bidx_idx} :
                                                  {seq_q, blk[BLK_W-1:0]};

  pkvm_ram #(
    .WIDTH(PHYS_BLOCK_BITS),
    .DEPTH(TBL_DEPTH)
  ) u_tbl (
    .clk  (clk),
    .we   (tbl_we),
    .addr (tbl_addr),
    .wdata(PHYS_BLOCK_BITS'(32'(phys_block))),
    .rdata(pb_rd)
  );

  pkvm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (bs_q),
    .done    (div_done),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  // ceil((cached + n) / bs) as floor((cached + n + bs - 1) / bs)
  assign need_num = DIV_W'(cached_q) + DIV_W'(n_q) + DIV_W'(bs_q) - DIV_W'(1);

  assign base_qs  = start_q ? '0 : qs_acc;
  assign base_tot = start_q ? '0 : tot_acc;
  assign base_max = start_q ? '0 : max_seen;
  assign qs_sum   = {1'b0, base_qs} + (ACC_W + 1)'(n_q);
  assign tot_sum  = {1'b0, base_tot} + (ACC_W + 1)'(n_q);
  assign qs_new   = qs_sum[ACC_W] ? pkvm_pkg::ACC_MAX : qs_sum[ACC_W-1:0];
  assign tot_new  = tot_sum[ACC_W] ? pkvm_pkg::ACC_MAX : tot_sum[ACC_W-1:0];

  always_comb begin
    max_new = base_max;
    if (32'(div_quot) > 32'(base_max)) begin
      max_new = (32'(div_quot) > 32'(pkvm_pkg::MAXB_MAX)) ?
                pkvm_pkg::MAXB_MAX : pkvm_pkg::MAXB_W'(div_quot);
    end
    if (32'(tot_new) > 32'(max_batched_tokens)) begin
      stat_new = pkvm_pkg::STATUS_LIMIT;
    end else if (32'(div_quot) > 32'(tlen_q)) begin
      stat_new = pkvm_pkg::STATUS_MISSING;
    end else begin
      stat_new = pkvm_pkg::STATUS_OK;
    end
  end

  assign out_free = !out_valid || out_ready;
  assign tok_last = (j + NTOK_W'(1)) == n_q;
  assign blk_wrap = (off == (bs_q - BS_W'(1)));

  // sequencer
  always_comb begin
    state_next    = state;
    div_start     = 1'b0;
    div_dividend  = need_num;
    out_load_tok  = 1'b0;
    out_load_flag = 1'b0;
    case (state)
      pkvm_pkg::S_IDLE: begin
        if (in_fire && (req_type == pkvm_pkg::REQ_SEQ)) begin
          state_next = pkvm_pkg::S_LOOKUP;
        end
      end
      pkvm_pkg::S_LOOKUP: begin
        div_start  = 1'b1;
        state_next = pkvm_pkg::S_NEED;
      end
      pkvm_pkg::S_NEED: begin
        if (div_done) begin
          if ((stat_new != pkvm_pkg::STATUS_OK) || (n_q == '0)) begin
            state_next = pkvm_pkg::S_FLAG;
          end else begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(cached_q);
            state_next   = pkvm_pkg::S_POS;
          end
        end
      end
      pkvm_pkg::S_POS: begin
        if (div_done) begin
          state_next = pkvm_pkg::S_RD;
        end
      end
      pkvm_pkg::S_RD: begin
        state_next = pkvm_pkg::S_MUL;
      end
      pkvm_pkg::S_MUL: begin
        state_next = pkvm_pkg::S_PUT;
      end
      pkvm_pkg::S_PUT: begin
        if (out_free) begin
          out_load_tok = 1'b1;
          if (tok_last) begin
            state_next = pkvm_pkg::S_IDLE;
          end else if (blk_wrap) begin
            state_next = pkvm_pkg::S_RD;
          end
        end
      end
      pkvm_pkg::S_FLAG: begin
        if (out_free) begin
          out_load_flag = 1'b1;
          state_next    = pkvm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pkvm_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= pkvm_pkg::S_IDLE;
      block_size         <= pkvm_pkg::BS_RESET;
      max_batched_tokens <= pkvm_pkg::MBT_RESET;
      qs_acc             <= '0;
      tot_acc            <= '0;
      max_seen           <= '0;
      lvalid             <= '0;
      out_valid          <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          pkvm_pkg::CFG_BLOCK_SIZE:  block_size         <= cfg_data[BS_W-1:0];
          pkvm_pkg::CFG_MAX_BATCHED: max_batched_tokens <= cfg_data;
          default: ;
        endcase
      end
      if (tbl_we) begin
        lvalid[seq_in_idx] <= 1'b1;
      end
      if ((state == pkvm_pkg::S_NEED) && div_done) begin
        qs_acc   <= qs_new;
        tot_acc  <= tot_new;
        max_seen <= max_new;
      end
      if (out_load_tok || out_load_flag) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      start_q  <= start_batch;
      seq_q    <= seq_in_idx;
      seq_ok_q <= seq_in_ok;
      n_q      <= n_clamp;
      cached_q <= cached_len;
      bs_q     <= bs_eff;
    end
    if (state == pkvm_pkg::S_LOOKUP) begin
      tlen_q <= (seq_ok_q && lvalid[seq_q]) ? lcnt_rd : '0;
    end
    if ((state == pkvm_pkg::S_NEED) && div_done) begin
      qs_q <= base_qs;
    end
    if ((state == pkvm_pkg::S_POS) && div_done) begin
      blk <= div_quot;
      off <= div_rem;
      j   <= '0;
    end
    if (state == pkvm_pkg::S_MUL) begin
      prod <= PROD_W'(pb_rd) * PROD_W'(bs_q);
    end
    if (out_load_tok) begin
      j <= j + NTOK_W'(1);
      if (blk_wrap) begin
        off <= '0;
        blk <= blk + DIV_W'(1);
      end else begin
        off <= off + BS_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load_tok) begin
      token_valid <= 1'b1;
      position    <= pkvm_pkg::POS_W'(cached_q) + pkvm_pkg::POS_W'(j);
      slot        <= pkvm_pkg::SLOT_W'(64'(prod) + 64'(off));
      token_index <= pkvm_pkg::TIX_W'(qs_q + ACC_W'(j));
      query_start <= qs_q[pkvm_pkg::QS_W-1:0];
      max_blocks  <= max_seen;
      status      <= pkvm_pkg::STATUS_OK;
      last        <= tok_last;
    end else if (out_load_flag) begin
      token_valid <= 1'b0;
      position    <= '0;
      slot        <= '0;
      token_index <= '0;
      query_start <= qs_q[pkvm_pkg::QS_W-1:0];
      max_blocks  <= max_seen;
      status      <= stat_flag;
      last        <= 1'b1;
    end
  end

  // status of a flagged request, latched when the blocks-needed divide completes
  always_ff @(posedge clk) begin
    if ((state == pkvm_pkg::S_NEED) && div_done) begin
      stat_flag <= stat_new;
    end
  end

`ifndef SYNTH
  // a request that passed the table check never reads past its table
  a_blk_range: assert property (@(posedge clk) disable iff (rst)
    (state == pkvm_pkg::S_RD) |-> (32'(blk) < 32'(MAX_BLOCKS_PER_SEQ)))
    else $error("block index out of table range");

  a_off_range: assert property (@(posedge clk) disable iff (rst)
    (state == pkvm_pkg::S_PUT) |-> (off < bs_q))
    else $error("offset not below block size");

  a_flag_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !token_valid) |-> (last && (position == '0) && (slot == '0)))
    else $error("non-token result malformed");
`endif

endmodule

`default_nettype wire
